### rtl/cei_pkg.sv
// shared types and constants of the integer alu
// operation codes, status codes, default data width; no dependencies
package cei_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int MODE_WIDTH     = 5;
    localparam int STATUS_WIDTH   = 2;
    localparam int SHAMT_WIDTH    = 5;

    typedef enum logic [MODE_WIDTH-1:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_DIV  = 5'd3,
        OP_MOD  = 5'd4,
        OP_AND  = 5'd5,
        OP_OR   = 5'd6,
        OP_XOR  = 5'd7,
        OP_SHL  = 5'd8,
        OP_SRA  = 5'd9,
        OP_LAND = 5'd10,
        OP_LOR  = 5'd11,
        OP_GT   = 5'd12,
        OP_LT   = 5'd13,
        OP_EQ   = 5'd14,
        OP_POS  = 5'd15,
        OP_NEG  = 5'd16,
        OP_NOT  = 5'd17,
        OP_LNOT = 5'd18
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_BADOP   = 2'd2
    } status_t;

endpackage

### rtl/cei_if.sv
// valid/ready channels of the integer alu: request and response
// depends on cei_pkg for field widths
interface cei_req_if #(
    parameter int DATA_WIDTH = cei_pkg::DATA_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic [cei_pkg::MODE_WIDTH-1:0]    mode;
    logic signed [DATA_WIDTH-1:0]      operand_a;
    logic signed [DATA_WIDTH-1:0]      operand_b;

    modport source (output valid, mode, operand_a, operand_b, input ready);
    modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface cei_rsp_if #(
    parameter int DATA_WIDTH = cei_pkg::DATA_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [DATA_WIDTH-1:0]      result;
    logic [cei_pkg::STATUS_WIDTH-1:0]  status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

### rtl/cei_mul.sv
// two-stage multiplier keeping the low DATA_WIDTH bits of the product
// split into half-width partial products; depends on cei_pkg
module cei_mul #(
    parameter int DATA_WIDTH = cei_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic [DATA_WIDTH-1:0] product
);
    localparam int H  = (DATA_WIDTH + 1) / 2;
    localparam int LH = DATA_WIDTH - H;

    logic [2*H-1:0] ll_reg, ll_next;
    logic [LH-1:0]  c1_reg, c1_next;
    logic [LH-1:0]  c2_reg, c2_next;
    logic [DATA_WIDTH-1:0] prod_reg, prod_next;

    always_comb
    begin
        ll_next = {{H{1'b0}}, a[H-1:0]} * {{H{1'b0}}, b[H-1:0]};
        c1_next = LH'(a[H-1:0] * b[DATA_WIDTH-1:H]);
        c2_next = LH'(a[DATA_WIDTH-1:H] * b[H-1:0]);
        prod_next = DATA_WIDTH'(ll_reg)
                  + {LH'(c1_reg + c2_reg), {H{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg   <= ll_next;
            c1_reg   <= c1_next;
            c2_reg   <= c2_next;
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;
endmodule

### rtl/cei_div.sv
// unsigned restoring divider, one quotient bit per pipeline stage
// DATA_WIDTH stages; depends on cei_pkg
module cei_div #(
    parameter int DATA_WIDTH = cei_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);
    localparam int W = DATA_WIDTH;

    logic [W-1:0] rem_reg [W];
    logic [W-1:0] num_reg [W];
    logic [W-1:0] den_reg [W];

    for (genvar k = 0; k < W; k++)
    begin : g_stage
        logic [W-1:0] rem_prev, num_prev, den_prev;
        logic [W-1:0] rem_next, num_next;
        logic [W:0]   trial, diff;

        if (k == 0)
        begin : g_first
            assign rem_prev = '0;
            assign num_prev = dividend;
            assign den_prev = divisor;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign num_prev = num_reg[k-1];
            assign den_prev = den_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_prev, num_prev[W-1]};
            diff  = trial - {1'b0, den_prev};
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                num_next = {num_prev[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                num_next = {num_prev[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                num_reg[k] <= num_next;
                den_reg[k] <= den_prev;
            end
        end
    end

    assign quotient  = num_reg[W-1];
    assign remainder = rem_reg[W-1];
endmodule

### rtl/c_expression_integer_alu.sv
// top level of the pipelined signed integer alu with c expression semantics
// depends on cei_pkg, cei_if, cei_mul, cei_div
//
// usage: a request transfer on req carries mode, operand_a and operand_b; each
// request yields exactly one response transfer on rsp with result and status.
// status is 0 ok, 1 division by zero (result 0), 2 unknown mode (result 0).
// path: a request travels through one input stage, DATA_WIDTH divider stages
// (one quotient bit each, which sets the depth) and one output register before
// rsp.valid rises. every operation travels the same depth so responses stay
// in request order.
// throughput is one transfer per cycle while rsp.ready is high.
// when rsp holds a valid response that is not taken, the whole pipeline
// freezes and req.ready drops; nothing is lost or repeated. bubbles are not
// squeezed out, so a stall holds exactly while the output is occupied.
// reset (rst_n low) clears all valid bits; the data registers are not reset.
module c_expression_integer_alu #(
    parameter int DATA_WIDTH = cei_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cei_req_if.sink       req,
    cei_rsp_if.source     rsp
);
    localparam int W = DATA_WIDTH;

    typedef struct packed {
        logic         is_mul;
        logic         is_div;
        logic         is_mod;
        logic         neg_q;
        logic         neg_r;
        logic [cei_pkg::STATUS_WIDTH-1:0] status;
        logic [W-1:0] value;
    } side_t;

    logic adv;

    logic                            s1_valid_reg;
    logic [cei_pkg::MODE_WIDTH-1:0]  s1_mode_reg;
    logic signed [W-1:0]             s1_a_reg;
    logic signed [W-1:0]             s1_b_reg;

    side_t        side_next;
    side_t        side_reg  [1:W];
    logic [1:W]   side_valid_reg;

    logic [W-1:0] mag_a, mag_b;
    logic [W-1:0] mul_p, div_q, div_r;

    logic                            out_valid_reg;
    logic [W-1:0]                    out_result_reg, out_result_next;
    logic [cei_pkg::STATUS_WIDTH-1:0] out_status_reg;

    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mode_reg <= req.mode;
            s1_a_reg    <= req.operand_a;
            s1_b_reg    <= req.operand_b;
        end
    end

    // simple operations and divider setup from the input stage
    always_comb
    begin
        logic [cei_pkg::SHAMT_WIDTH-1:0] sh;
        sh = s1_b_reg[cei_pkg::SHAMT_WIDTH-1:0];
        mag_a = s1_a_reg[W-1] ? -s1_a_reg : s1_a_reg;
        mag_b = s1_b_reg[W-1] ? -s1_b_reg : s1_b_reg;

        side_next        = '0;
        side_next.status = cei_pkg::ST_OK;
        side_next.neg_q  = s1_a_reg[W-1] ^ s1_b_reg[W-1];
        side_next.neg_r  = s1_a_reg[W-1];
        unique case (cei_pkg::op_t'(s1_mode_reg))
            cei_pkg::OP_ADD:  side_next.value = s1_a_reg + s1_b_reg;
            cei_pkg::OP_SUB:  side_next.value = s1_a_reg - s1_b_reg;
            cei_pkg::OP_MUL:  side_next.is_mul = 1'b1;
            cei_pkg::OP_DIV, cei_pkg::OP_MOD:
            begin
                side_next.is_div = (s1_mode_reg == cei_pkg::OP_DIV);
                side_next.is_mod = (s1_mode_reg == cei_pkg::OP_MOD);
                if (s1_b_reg == '0)
                    side_next.status = cei_pkg::ST_DIVZERO;
            end
            cei_pkg::OP_AND:  side_next.value = s1_a_reg & s1_b_reg;
            cei_pkg::OP_OR:   side_next.value = s1_a_reg | s1_b_reg;
            cei_pkg::OP_XOR:  side_next.value = s1_a_reg ^ s1_b_reg;
            cei_pkg::OP_SHL:  side_next.value = s1_a_reg << sh;
            cei_pkg::OP_SRA:  side_next.value = s1_a_reg >>> sh;
            cei_pkg::OP_LAND:
                side_next.value = W'((s1_a_reg != '0) && (s1_b_reg != '0));
            cei_pkg::OP_LOR:
                side_next.value = W'((s1_a_reg != '0) || (s1_b_reg != '0));
            cei_pkg::OP_GT:   side_next.value = W'(s1_a_reg > s1_b_reg);
            cei_pkg::OP_LT:   side_next.value = W'(s1_a_reg < s1_b_reg);
            cei_pkg::OP_EQ:   side_next.value = W'(s1_a_reg == s1_b_reg);
            cei_pkg::OP_POS:  side_next.value = s1_a_reg;
            cei_pkg::OP_NEG:  side_next.value = -s1_a_reg;
            cei_pkg::OP_NOT:  side_next.value = ~s1_a_reg;
            cei_pkg::OP_LNOT: side_next.value = W'(s1_a_reg == '0);
            default:          side_next.status = cei_pkg::ST_BADOP;
        endcase
    end

    cei_mul #(.DATA_WIDTH(W)) u_mul (
        .clk     (clk),
        .en      (adv),
        .a       (s1_a_reg),
        .b       (s1_b_reg),
        .product (mul_p)
    );

    cei_div #(.DATA_WIDTH(W)) u_div (
        .clk       (clk),
        .en        (adv),
        .dividend  (mag_a),
        .divisor   (mag_b),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // side line runs beside the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_valid_reg <= '0;
        else if (adv)
            side_valid_reg <= {s1_valid_reg, side_valid_reg[1:W-1]};
    end

    for (genvar k = 1; k <= W; k++)
    begin : g_side
        if (k == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                    side_reg[k] <= side_next;
            end
        end
        else if (k == 3)
        begin : g_mul
            side_t side_mul_next;

            // multiplier product lines up with this stage
            always_comb
            begin
                side_mul_next = side_reg[k-1];
                if (side_reg[k-1].is_mul)
                    side_mul_next.value = mul_p;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    side_reg[k] <= side_mul_next;
            end
        end
        else
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (adv)
                    side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // output register
    always_comb
    begin
        out_result_next = side_reg[W].value;
        if (side_reg[W].status == cei_pkg::ST_OK)
        begin
            if (side_reg[W].is_div)
                out_result_next = side_reg[W].neg_q ? -div_q : div_q;
            else if (side_reg[W].is_mod)
                out_result_next = side_reg[W].neg_r ? -div_r : div_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= side_valid_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_result_reg <= out_result_next;
            out_status_reg <= side_reg[W].status;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.result = out_result_reg;
    assign rsp.status = out_status_reg;

    // checks
    a_divzero_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == cei_pkg::ST_DIVZERO |-> rsp.result == '0)
        else $error("division by zero response carries nonzero result");

    a_badop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == cei_pkg::ST_BADOP |-> rsp.result == '0)
        else $error("unknown mode response carries nonzero result");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.status != 2'd3)
        else $error("reserved status code on response");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |=> $stable(side_valid_reg) && s1_valid_reg == $past(s1_valid_reg))
        else $error("pipeline moved during a stall");
endmodule

### tb/sv/tb_c_expression_integer_alu.sv
// self-checking testbench of the pipelined signed integer alu
// depends on cei_pkg, cei_if and c_expression_integer_alu
`timescale 1ns / 1ps

module tb_c_expression_integer_alu;

    localparam int W = cei_pkg::DATA_WIDTH_DEF;
    localparam int MW = cei_pkg::MODE_WIDTH;
    localparam int SW = cei_pkg::STATUS_WIDTH;
    localparam int N_RANDOM = 1600;
    localparam int LATENCY = W + 2;

    typedef struct packed {
        logic [MW-1:0]         mode;
        logic signed [W-1:0]   a;
        logic signed [W-1:0]   b;
    } alu_op_t;

    typedef struct packed {
        logic signed [W-1:0]     value;
        logic [SW-1:0]           st;
    } alu_res_t;

    typedef struct {
        alu_op_t  op;
        logic     known;
        alu_res_t res;
    } vec_t;

    localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] ALL1  = '1;

    logic clk;
    logic rst_n;

    cei_req_if #(.DATA_WIDTH(W)) req ();
    cei_rsp_if #(.DATA_WIDTH(W)) rsp ();

    c_expression_integer_alu #(.DATA_WIDTH(W)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    alu_res_t pending_results[$];
    int       mismatch_count;
    int       error_count;
    bit       long_hold;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // predicted result of one operation
    function automatic alu_res_t compute_alu(alu_op_t op);
        alu_res_t             r;
        logic signed [W-1:0]  a;
        logic signed [W-1:0]  b;
        logic [W-1:0]         ma;
        logic [W-1:0]         mb;
        logic [W-1:0]         q;
        logic [cei_pkg::SHAMT_WIDTH-1:0] sh;
        a = op.a;
        b = op.b;
        sh = b[cei_pkg::SHAMT_WIDTH-1:0];
        r.st = cei_pkg::ST_OK;
        r.value = '0;
        ma = a[W-1] ? -a : a;
        mb = b[W-1] ? -b : b;
        unique case (op.mode)
            cei_pkg::OP_ADD:  r.value = a + b;
            cei_pkg::OP_SUB:  r.value = a - b;
            cei_pkg::OP_MUL:  r.value = a * b;
            cei_pkg::OP_DIV, cei_pkg::OP_MOD:
            begin
                if (b == '0)
                    r.st = cei_pkg::ST_DIVZERO;
                else if (op.mode == cei_pkg::OP_DIV)
                begin
                    q = ma / mb;
                    r.value = (a[W-1] != b[W-1]) ? -q : q;
                end
                else
                begin
                    q = ma % mb;
                    r.value = a[W-1] ? -q : q;
                end
            end
            cei_pkg::OP_AND:  r.value = a & b;
            cei_pkg::OP_OR:   r.value = a | b;
            cei_pkg::OP_XOR:  r.value = a ^ b;
            cei_pkg::OP_SHL:  r.value = a << sh;
            cei_pkg::OP_SRA:  r.value = a >>> sh;
            cei_pkg::OP_LAND: r.value = W'(a != '0 && b != '0);
            cei_pkg::OP_LOR:  r.value = W'(a != '0 || b != '0);
            cei_pkg::OP_GT:   r.value = W'(a > b);
            cei_pkg::OP_LT:   r.value = W'(a < b);
            cei_pkg::OP_EQ:   r.value = W'(a == b);
            cei_pkg::OP_POS:  r.value = a;
            cei_pkg::OP_NEG:  r.value = -a;
            cei_pkg::OP_NOT:  r.value = ~a;
            cei_pkg::OP_LNOT: r.value = W'(a == '0);
            default:          r.st = cei_pkg::ST_BADOP;
        endcase
        return r;
    endfunction

    function automatic vec_t row(logic [MW-1:0] m, logic signed [W-1:0] a,
                                 logic signed [W-1:0] b, logic known,
                                 logic signed [W-1:0] v, logic [SW-1:0] st);
        vec_t x;
        x.op = '{m, a, b};
        x.known = known;
        x.res = '{v, st};
        return x;
    endfunction

    function automatic logic signed [W-1:0] rand_operand();
        logic signed [W-1:0] v;
        v = W'($urandom);
        case ($urandom_range(0, 7))
            0: v = W'($urandom_range(0, 3)) - W'(1);
            1: v = MIN_V;
            2: v = MAX_V;
            3: v = v >>> $urandom_range(8, 30);
            default: ;
        endcase
        return v;
    endfunction

    // one transfer on the request channel, sender stays at falling-edge timing
    task automatic send_op(alu_op_t op);
        req.valid     <= 1'b1;
        req.mode      <= op.mode;
        req.operand_a <= op.a;
        req.operand_b <= op.b;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        req.valid <= 1'b0;
        repeat (cycles)
            @(negedge clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // response checking
    always @(posedge clk)
    begin
        alu_res_t exp_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (mismatch_count++ < 10)
                    $display("unexpected result %0d status %0d", rsp.result, rsp.status);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (rsp.result !== exp_r.value || rsp.status !== exp_r.st)
                begin
                    error_count++;
                    if (mismatch_count++ < 10)
                        $display("mismatch: expected %0d/%0d got %0d/%0d",
                                 exp_r.value, exp_r.st, rsp.result, rsp.status);
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    initial
    begin
        int phase;
        rsp.ready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            phase++;
            if (long_hold)
                rsp.ready <= 1'b0;
            else if ((phase % 64) < 20)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        vec_t     vecs[$];
        alu_op_t  op;
        int       burst;
        int       sent;
        int       k;
        bit       hold_done;
        bit       drain_done;
        req.valid = 1'b0;
        req.mode = '0;
        req.operand_a = '0;
        req.operand_b = '0;
        rst_n = 1'b0;
        mismatch_count = 0;
        error_count = 0;
        long_hold = 1'b0;
        hold_done = 1'b0;
        drain_done = 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        vecs.push_back(row(cei_pkg::OP_ADD, MAX_V, 1, 1'b1, MIN_V, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_SUB, MIN_V, 1, 1'b1, MAX_V, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_MUL, MIN_V, ALL1, 1'b1, MIN_V, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_DIV, 7, 0, 1'b1, 0, cei_pkg::ST_DIVZERO));
        vecs.push_back(row(cei_pkg::OP_MOD, MIN_V, 0, 1'b1, 0, cei_pkg::ST_DIVZERO));
        vecs.push_back(row(cei_pkg::OP_DIV, MIN_V, ALL1, 1'b1, MIN_V, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_MOD, MIN_V, ALL1, 1'b1, 0, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_DIV, -7, 2, 1'b1, -3, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_MOD, -7, 2, 1'b1, -1, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_AND, 32'h0ff0, 32'h00ff, 1'b1, 32'h00f0,
                           cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_OR, MIN_V, MAX_V, 1'b1, ALL1, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_XOR, ALL1, MAX_V, 1'b1, MIN_V, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_SHL, 1, 32'h0000_003f, 1'b1, MIN_V, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_SRA, MIN_V, 31, 1'b1, ALL1, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_SRA, MAX_V, 32'hffff_ffe1, 1'b1, 32'h3fff_ffff,
                           cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_LAND, MIN_V, 0, 1'b1, 0, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_LOR, 0, MIN_V, 1'b1, 1, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_GT, MAX_V, MIN_V, 1'b1, 1, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_LT, MAX_V, MIN_V, 1'b1, 0, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_EQ, ALL1, ALL1, 1'b1, 1, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_POS, MIN_V, 5, 1'b1, MIN_V, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_NEG, MIN_V, 5, 1'b1, MIN_V, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_NOT, 0, ALL1, 1'b1, ALL1, cei_pkg::ST_OK));
        vecs.push_back(row(cei_pkg::OP_LNOT, 0, ALL1, 1'b1, 1, cei_pkg::ST_OK));
        vecs.push_back(row(5'd19, 3, 4, 1'b1, 0, cei_pkg::ST_BADOP));
        vecs.push_back(row(5'd31, ALL1, ALL1, 1'b1, 0, cei_pkg::ST_BADOP));

        foreach (vecs[i])
        begin
            pending_results.push_back(vecs[i].known ? vecs[i].res : compute_alu(vecs[i].op));
            send_op(vecs[i].op);
        end
        idle_sender(1);
        drain();

        sent = 0;
        while (sent < N_RANDOM)
        begin
            if (!hold_done && sent >= 400)
            begin
                // hold the output off long enough to fill the pipeline
                hold_done = 1'b1;
                long_hold = 1'b1;
                for (k = 0; k < 60; k++)
                begin
                    op.mode = MW'($urandom_range(0, 18));
                    op.a = rand_operand();
                    op.b = rand_operand();
                    pending_results.push_back(compute_alu(op));
                    if (k == 0)
                        fork
                            begin
                                repeat (120)
                                    @(negedge clk);
                                long_hold = 1'b0;
                            end
                        join_none
                    send_op(op);
                end
                sent += 60;
            end
            if (!drain_done && sent >= 900)
            begin
                drain_done = 1'b1;
                idle_sender(1);
                drain();
            end
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst; k++)
            begin
                op.mode = ($urandom_range(0, 19) == 0) ? MW'($urandom_range(19, 31))
                                                     : MW'($urandom_range(0, 18));
                op.a = rand_operand();
                op.b = rand_operand();
                pending_results.push_back(compute_alu(op));
                send_op(op);
            end
            sent += burst;
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 12));
        end
        idle_sender(1);
        drain();
        repeat (LATENCY + 10)
            @(negedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
